// File: src/textured_quad_u_pattern_splitter_unit_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef TEXTURED_QUAD_U_PATTERN_SPLITTER_UNIT_MACROS_SVH
`define TEXTURED_QUAD_U_PATTERN_SPLITTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TQUS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tqus assertion failed");
`define TQUS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tqus assertion failed");
`else
`define TQUS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TQUS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/tqus_pkg.sv
`default_nettype none
package tqus_pkg;
  localparam int MaxPieces = 64;
  localparam int CntW      = $clog2(MaxPieces);
  localparam int NumLanes  = 8;
  localparam int QuoW      = 25;
  localparam int DivCntW   = $clog2(QuoW);
  localparam int MidW      = 9;
  localparam int One       = 65536;

  typedef logic signed [23:0] coord_t;
  typedef logic [23:0]        frac_t;
  typedef logic [16:0]        tex_t;
  typedef logic signed [25:0] wide_t;

  typedef struct packed {
    frac_t n0;
    frac_t n1;
    tex_t  ul;
    tex_t  ur;
    logic  last;
  } piece_t;

  typedef struct packed {
    logic   valid;
    logic   swap;
    frac_t  d;
    piece_t piece;
  } seq_out_t;

  typedef struct packed {
    coord_t p;
    coord_t q;
    frac_t  n;
    frac_t  d;
  } lane_req_t;
endpackage
`default_nettype wire

// File: src/textured_quad_u_pattern_splitter_unit.sv
// Textured quad u-pattern splitter.
// Input channel: one beat carries a screen quad (four s15.8 corners) on
// in_valid_i / in_stall_o. Output channel: one beat per piece on
// out_valid_o / out_stall_i with the piece corners, u at both edges
// (1.16) and last_piece on the final piece of the quad.
// Configuration: cfg_we_i writes u_start (0), u_end (1) or wrap_clamp (2)
// from cfg_data_i; write only while no quad is in flight.
// Flow: a quad waits in the sequencer for the range setup, then each piece
// passes through eight interpolation lanes (one per corner coordinate);
// each lane runs a multiply and a 25-step restoring divide, one quotient
// bit per cycle. A new quad is taken once the last piece of the previous
// one sits in the output register. While the receiver stalls, the output
// beat holds and the lanes hold the next finished piece.
// Reset: clears all handshake state; u range resets to 0..1 in repeat mode.
`default_nettype none
`include "textured_quad_u_pattern_splitter_unit_macros.svh"
module textured_quad_u_pattern_splitter_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire logic signed [23:0] in_c0_x_i,
  input  wire logic signed [23:0] in_c0_y_i,
  input  wire logic signed [23:0] in_c1_x_i,
  input  wire logic signed [23:0] in_c1_y_i,
  input  wire logic signed [23:0] in_c2_x_i,
  input  wire logic signed [23:0] in_c2_y_i,
  input  wire logic signed [23:0] in_c3_x_i,
  input  wire logic signed [23:0] in_c3_y_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic signed [23:0] out_c0_x_o,
  output logic signed [23:0] out_c0_y_o,
  output logic signed [23:0] out_c1_x_o,
  output logic signed [23:0] out_c1_y_o,
  output logic signed [23:0] out_c2_x_o,
  output logic signed [23:0] out_c2_y_o,
  output logic signed [23:0] out_c3_x_o,
  output logic signed [23:0] out_c3_y_o,
  output logic [16:0] tex_u_left_o,
  output logic [16:0] tex_u_right_o,
  output logic        last_piece_o
);
  localparam logic [1:0] RegUStart = 2'd0;
  localparam logic [1:0] RegUEnd   = 2'd1;
  localparam logic [1:0] RegWrap   = 2'd2;

  tqus_pkg::coord_t u_start_q, u_end_q;
  logic             wrap_q;
  logic             busy_q;
  tqus_pkg::coord_t qx_q [4];
  tqus_pkg::coord_t qy_q [4];
  tqus_pkg::coord_t sx [4];
  tqus_pkg::coord_t sy [4];
  logic             launch_last_q;

  logic             out_valid_q, out_last_q;
  tqus_pkg::coord_t out_res_q [tqus_pkg::NumLanes];
  tqus_pkg::tex_t   out_ul_q, out_ur_q, ul_q, ur_q;

  tqus_pkg::seq_out_t  seq;
  tqus_pkg::lane_req_t req [tqus_pkg::NumLanes];
  tqus_pkg::coord_t    res [tqus_pkg::NumLanes];
  logic [tqus_pkg::NumLanes-1:0] ready, done;
  logic accept, launch, load;

  assign accept = in_valid_i && !busy_q;
  assign launch = seq.valid && ready[0];
  assign load   = done[0] && (!out_valid_q || !out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_start_q <= '0;
      u_end_q   <= 24'(tqus_pkg::One);
      wrap_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUStart: u_start_q <= cfg_data_i;
        RegUEnd:   u_end_q   <= cfg_data_i;
        RegWrap:   wrap_q    <= cfg_data_i[0];
        default:   wrap_q    <= wrap_q;
      endcase
    end
  end

  // hold the quad for the whole walk
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q[0] <= in_c0_x_i;  qy_q[0] <= in_c0_y_i;
      qx_q[1] <= in_c1_x_i;  qy_q[1] <= in_c1_y_i;
      qx_q[2] <= in_c2_x_i;  qy_q[2] <= in_c2_y_i;
      qx_q[3] <= in_c3_x_i;  qy_q[3] <= in_c3_y_i;
    end
    if (launch) begin
      launch_last_q <= seq.piece.last;
      ul_q          <= seq.piece.ul;
      ur_q          <= seq.piece.ur;
    end
    if (load) begin
      out_res_q  <= res;
      out_ul_q   <= ul_q;
      out_ur_q   <= ur_q;
      out_last_q <= launch_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load && launch_last_q) begin
        // drop busy once the final piece is parked in the output register
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  tqus_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .u_start_i    (u_start_q),
    .u_end_i      (u_end_q),
    .wrap_clamp_i (wrap_q),
    .start_i      (accept),
    .adv_i        (launch),
    .seq_o        (seq)
  );

  // reversed range: walk corners in 1,0,3,2 order
  always_comb begin
    sx[0] = seq.swap ? qx_q[1] : qx_q[0];  sy[0] = seq.swap ? qy_q[1] : qy_q[0];
    sx[1] = seq.swap ? qx_q[0] : qx_q[1];  sy[1] = seq.swap ? qy_q[0] : qy_q[1];
    sx[2] = seq.swap ? qx_q[3] : qx_q[2];  sy[2] = seq.swap ? qy_q[3] : qy_q[2];
    sx[3] = seq.swap ? qx_q[2] : qx_q[3];  sy[3] = seq.swap ? qy_q[2] : qy_q[3];
    // output corners 0 and 1 cut the edge from corner 0 to corner 1, corners 3 and 2 the edge from corner 3 to corner 2
    req[0] = '{p: sx[0], q: sx[1], n: seq.piece.n0, d: seq.d};
    req[1] = '{p: sy[0], q: sy[1], n: seq.piece.n0, d: seq.d};
    req[2] = '{p: sx[0], q: sx[1], n: seq.piece.n1, d: seq.d};
    req[3] = '{p: sy[0], q: sy[1], n: seq.piece.n1, d: seq.d};
    req[4] = '{p: sx[3], q: sx[2], n: seq.piece.n1, d: seq.d};
    req[5] = '{p: sy[3], q: sy[2], n: seq.piece.n1, d: seq.d};
    req[6] = '{p: sx[3], q: sx[2], n: seq.piece.n0, d: seq.d};
    req[7] = '{p: sy[3], q: sy[2], n: seq.piece.n0, d: seq.d};
  end

  for (genvar gi = 0; gi < tqus_pkg::NumLanes; gi++) begin : g_lane
    tqus_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (launch),
      .req_i   (req[gi]),
      .take_i  (load),
      .ready_o (ready[gi]),
      .done_o  (done[gi]),
      .res_o   (res[gi])
    );
  end

  assign in_stall_o    = busy_q;
  assign out_valid_o   = out_valid_q;
  assign out_c0_x_o    = out_res_q[0];
  assign out_c0_y_o    = out_res_q[1];
  assign out_c1_x_o    = out_res_q[2];
  assign out_c1_y_o    = out_res_q[3];
  assign out_c2_x_o    = out_res_q[4];
  assign out_c2_y_o    = out_res_q[5];
  assign out_c3_x_o    = out_res_q[6];
  assign out_c3_y_o    = out_res_q[7];
  assign tex_u_left_o  = out_ul_q;
  assign tex_u_right_o = out_ur_q;
  assign last_piece_o  = out_last_q;

  `TQUS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, busy_q)
  `TQUS_ASSERT_IMP(a_lanes_lockstep, clk_i, rst_ni, 1'b1,
                   (done == '0 || done == '1) && (ready == '0 || ready == '1))
  `TQUS_ASSERT_NXT(a_last_frees_input, clk_i, rst_ni, load && launch_last_q, !busy_q)
  `TQUS_ASSERT_IMP(a_launch_only_busy, clk_i, rst_ni, launch, busy_q)
endmodule
`default_nettype wire

// File: src/tqus_lane.sv
`default_nettype none
// One interpolation lane: p + round((q - p) * n / d), ties toward plus infinity.
module tqus_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire tqus_pkg::lane_req_t req_i,
  input  wire logic               take_i,
  output logic                    ready_o,
  output logic                    done_o,
  output tqus_pkg::coord_t        res_o
);
  typedef enum logic [2:0] {
    LnIdle, LnMul, LnNorm, LnDiv, LnFin, LnHold
  } lane_state_e;

  lane_state_e                    state_q;
  tqus_pkg::coord_t               p_q, q_q, res_q;
  tqus_pkg::frac_t                n_q, d_q;
  logic signed [49:0]             prod_q;
  logic [tqus_pkg::QuoW-1:0]      rem_q, dvd_q;
  logic                           neg_q;
  logic [tqus_pkg::DivCntW-1:0]   cnt_q;

  logic signed [24:0] diff;
  logic signed [24:0] nsig;
  logic signed [50:0] num;
  logic [50:0]        mag;
  logic [25:0]        trial;
  logic [25:0]        dsor;
  logic               ge;
  tqus_pkg::wide_t    adj;
  tqus_pkg::wide_t    sum;

  always_comb begin
    diff  = 25'(q_q) - 25'(p_q);
    nsig  = $signed({1'b0, n_q});
    num   = $signed({prod_q, 1'b0}) + $signed({27'd0, d_q});
    mag   = num[50] ? 51'(-num) : 51'(num);
    trial = {rem_q, dvd_q[tqus_pkg::QuoW-1]};
    dsor  = {1'b0, d_q, 1'b0};
    ge    = trial >= dsor;
    if (neg_q) begin
      adj = (rem_q != '0) ? -($signed({1'b0, dvd_q}) + 26'sd1) : -$signed({1'b0, dvd_q});
    end else begin
      adj = $signed({1'b0, dvd_q});
    end
    sum = 26'(p_q) + adj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LnIdle;
    end else begin
      unique case (state_q)
        LnIdle: begin
          if (start_i) begin
            p_q     <= req_i.p;
            q_q     <= req_i.q;
            n_q     <= req_i.n;
            d_q     <= req_i.d;
            state_q <= LnMul;
          end
        end
        LnMul: begin
          prod_q  <= 50'(diff * nsig);
          state_q <= LnNorm;
        end
        LnNorm: begin
          neg_q   <= num[50];
          rem_q   <= mag[49:25];
          dvd_q   <= mag[24:0];
          cnt_q   <= '0;
          state_q <= LnDiv;
        end
        LnDiv: begin
          rem_q <= ge ? 25'(trial - dsor) : trial[24:0];
          dvd_q <= {dvd_q[tqus_pkg::QuoW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == tqus_pkg::DivCntW'(tqus_pkg::QuoW - 1)) begin
            state_q <= LnFin;
          end
        end
        LnFin: begin
          res_q   <= sum[23:0];
          state_q <= LnHold;
        end
        LnHold: begin
          if (take_i) begin
            state_q <= LnIdle;
          end
        end
        default: state_q <= LnIdle;
      endcase
    end
  end

  assign ready_o = (state_q == LnIdle);
  assign done_o  = (state_q == LnHold);
  assign res_o   = res_q;
endmodule
`default_nettype wire

// File: src/tqus_seq.sv
`default_nettype none
// Piece sequencer: walks the pieces of one quad and hands out cut fractions.
module tqus_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tqus_pkg::coord_t u_start_i,
  input  wire tqus_pkg::coord_t u_end_i,
  input  wire logic             wrap_clamp_i,
  input  wire logic             start_i,
  input  wire logic             adv_i,
  output tqus_pkg::seq_out_t    seq_o
);
  localparam tqus_pkg::wide_t WOne = tqus_pkg::wide_t'(tqus_pkg::One);

  typedef enum logic [3:0] {
    SqIdle, SqPrep, SqSingle, SqRStart, SqRMid, SqREnd, SqCLo, SqCMid, SqCHi
  } seq_state_e;

  // stage 1
  tqus_pkg::wide_t a1_q, b1_q;
  logic            sw1_q, sg1_q, wr1_q;
  tqus_pkg::tex_t  sl1_q, sr1_q;
  // stage 2
  tqus_pkg::wide_t a2_q, b2_q, d2_q, ce2_q, fl2_q, na2_q, om2_q;
  logic            sw2_q, sg2_q, wr2_q;
  tqus_pkg::tex_t  sl2_q, sr2_q;
  // stage 3
  tqus_pkg::wide_t a_q, b_q, d_q, na_q, om_q, first_q, lastv_q, urs_q;
  logic [tqus_pkg::MidW-1:0] nmid_q;
  logic            sw_q, sg_q, wr_q;
  tqus_pkg::tex_t  sl_q, sr_q;

  seq_state_e                 state_q;
  logic [1:0]                 wait_q;
  logic [tqus_pkg::CntW-1:0]  cnt_q;
  logic [tqus_pkg::MidW-1:0]  j_q;
  tqus_pkg::wide_t            du_q;

  logic            swap;
  tqus_pkg::tex_t  uclamp;
  tqus_pkg::wide_t ua, ub, t_ce, t_urs;
  seq_state_e      first_e, nxt_e;
  logic            is_last;
  tqus_pkg::wide_t n0, n1;
  tqus_pkg::tex_t  ul, ur;

  always_comb begin
    swap = u_end_i < u_start_i;
    ua   = 26'(swap ? u_end_i : u_start_i);
    ub   = 26'(swap ? u_start_i : u_end_i);
    if (u_start_i < 0) begin
      uclamp = '0;
    end else if (26'(u_start_i) > WOne) begin
      uclamp = 17'(tqus_pkg::One);
    end else begin
      uclamp = u_start_i[16:0];
    end
    t_ce  = ((a1_q + WOne - 26'sd1) >>> 16) <<< 16;
    t_urs = b2_q + WOne - ce2_q;
  end

  // Derived range values follow the registers continuously.
  always_ff @(posedge clk_i) begin
    sw1_q <= swap;
    a1_q  <= ua;
    b1_q  <= ub;
    wr1_q <= wrap_clamp_i;
    if (u_start_i == '0 && 26'(u_end_i) == WOne) begin
      sg1_q <= 1'b1;
      sl1_q <= '0;
      sr1_q <= 17'(tqus_pkg::One);
    end else begin
      sg1_q <= (u_start_i == u_end_i);
      sl1_q <= wrap_clamp_i ? uclamp : {1'b0, u_start_i[15:0]};
      sr1_q <= wrap_clamp_i ? uclamp : {1'b0, u_start_i[15:0]};
    end
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    d2_q  <= b1_q - a1_q;
    ce2_q <= t_ce;
    fl2_q <= (b1_q >>> 16) <<< 16;
    na2_q <= -a1_q;
    om2_q <= WOne - a1_q;
    sw2_q <= sw1_q;
    sg2_q <= sg1_q;
    wr2_q <= wr1_q;
    sl2_q <= sl1_q;
    sr2_q <= sr1_q;
    a_q     <= a2_q;
    b_q     <= b2_q;
    d_q     <= d2_q;
    na_q    <= na2_q;
    om_q    <= om2_q;
    first_q <= ce2_q - a2_q;
    lastv_q <= b2_q - fl2_q;
    nmid_q  <= tqus_pkg::MidW'((fl2_q - ce2_q) >>> 16);
    urs_q   <= (t_urs > WOne) ? WOne : t_urs;
    sw_q    <= sw2_q;
    sg_q    <= sg2_q;
    wr_q    <= wr2_q;
    sl_q    <= sl2_q;
    sr_q    <= sr2_q;
  end

  always_comb begin
    if (sg_q) begin
      first_e = SqSingle;
    end else if (wr_q) begin
      first_e = (a_q < 0) ? SqCLo : ((a_q < WOne) ? SqCMid : SqCHi);
    end else begin
      first_e = (first_q != '0) ? SqRStart : ((nmid_q != '0) ? SqRMid : SqREnd);
    end

    case (state_q)
      SqRStart: begin
        if (first_q >= d_q) begin
          nxt_e = SqIdle;
        end else if (nmid_q != '0) begin
          nxt_e = SqRMid;
        end else begin
          nxt_e = (lastv_q != '0) ? SqREnd : SqIdle;
        end
      end
      SqRMid: begin
        if (j_q + 1'b1 == nmid_q) begin
          nxt_e = (lastv_q != '0) ? SqREnd : SqIdle;
        end else begin
          nxt_e = SqRMid;
        end
      end
      SqCLo:   nxt_e = (na_q >= d_q) ? SqIdle : SqCMid;
      SqCMid:  nxt_e = (om_q < d_q) ? SqCHi : SqIdle;
      default: nxt_e = SqIdle;
    endcase
    is_last = (nxt_e == SqIdle) ||
              (cnt_q == tqus_pkg::CntW'(tqus_pkg::MaxPieces - 1));

    n0 = '0;
    n1 = d_q;
    ul = '0;
    ur = 17'(tqus_pkg::One);
    case (state_q)
      SqSingle: begin
        n1 = 26'sd1;
        ul = sl_q;
        ur = sr_q;
      end
      SqRStart: begin
        n1 = (first_q < d_q) ? first_q : d_q;
        ul = 17'(WOne - first_q);
        ur = urs_q[16:0];
      end
      SqRMid: begin
        n0 = du_q;
        n1 = du_q + WOne;
      end
      SqREnd: begin
        n0 = d_q - lastv_q;
        ur = lastv_q[16:0];
      end
      SqCLo: begin
        n1 = (na_q < d_q) ? na_q : d_q;
        ur = '0;
      end
      SqCMid: begin
        n0 = (a_q < 0) ? na_q : '0;
        n1 = (om_q < d_q) ? om_q : d_q;
        ul = (a_q < 0) ? '0 : a_q[16:0];
        ur = (b_q > WOne) ? 17'(tqus_pkg::One) : b_q[16:0];
      end
      SqCHi: begin
        n0 = (om_q > 0) ? om_q : '0;
        ul = 17'(tqus_pkg::One);
      end
      default: begin
        n0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
      wait_q  <= '0;
      cnt_q   <= '0;
      j_q     <= '0;
      du_q    <= '0;
    end else begin
      unique case (state_q)
        SqIdle: begin
          if (start_i) begin
            state_q <= SqPrep;
            wait_q  <= '0;
          end
        end
        SqPrep: begin
          // let the range pipeline settle on freshly written registers
          wait_q <= wait_q + 1'b1;
          if (wait_q == 2'd3) begin
            state_q <= first_e;
            cnt_q   <= '0;
            j_q     <= '0;
            du_q    <= first_q;
          end
        end
        default: begin
          if (adv_i) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= is_last ? SqIdle : nxt_e;
            if (state_q == SqRMid) begin
              j_q  <= j_q + 1'b1;
              du_q <= du_q + WOne;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    seq_o.valid      = (state_q != SqIdle) && (state_q != SqPrep);
    seq_o.swap       = sg_q ? 1'b0 : sw_q;
    seq_o.d          = sg_q ? 24'd1 : d_q[23:0];
    seq_o.piece.n0   = n0[23:0];
    seq_o.piece.n1   = n1[23:0];
    seq_o.piece.ul   = ul;
    seq_o.piece.ur   = ur;
    seq_o.piece.last = is_last;
  end
endmodule
`default_nettype wire
